### sv/bls_pkg.sv
package bls_pkg;

  // field widths
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned POL_W      = 3;
  localparam int unsigned IN_IDX_W   = 4;
  localparam int unsigned OUT_IDX_W  = 4;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned EST_W      = 16;
  localparam int unsigned PEND_W     = 16;
  localparam int unsigned LAT_W      = 25;
  localparam int unsigned KEY_W      = LAT_W + 1;
  localparam int unsigned PROD_W     = EST_W + WEIGHT_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // divider: quotient bits retired per step
  localparam int unsigned DIV_BITS  = 5;
  localparam int unsigned DIV_STEPS = LAT_W / DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [POL_W-1:0] POL_RR         = POL_W'(0);
  localparam logic [POL_W-1:0] POL_LEAST_CONN = POL_W'(1);
  localparam logic [POL_W-1:0] POL_LATENCY    = POL_W'(2);
  localparam logic [POL_W-1:0] POL_PENDING    = POL_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = CFG_IDX_W'(1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                up;
    logic [EST_W-1:0]    established;
    logic [PEND_W-1:0]   pending;
    logic [LAT_W-1:0]    latency;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_MUL,
    ALU_DIV_LOAD,
    ALU_DIV_STEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e             op;
    logic [LAT_W-1:0]    a;
    logic [WEIGHT_W-1:0] b;
  } alu_req_t;

endpackage

### sv/bls_ram.sv
module bls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bls_alu.sv
module bls_alu import bls_pkg::*; (
  input  logic                    clk_i,
  input  alu_req_t                req_i,
  output logic [LAT_W-1:0]        res_o,
  output logic signed [KEY_W-1:0] key_o
);

  logic [LAT_W-1:0]    acc_q, acc_d;
  logic [WEIGHT_W-1:0] rem_q, rem_d;
  logic [WEIGHT_W-1:0] div_q, div_d;
  logic                neg_q, neg_d;
  logic [PROD_W-1:0]   prod;
  logic [LAT_W-1:0]    q;
  logic [WEIGHT_W:0]   part;
  logic [KEY_W-1:0]    mag;

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    div_d = div_q;
    neg_d = neg_q;
    prod  = PROD_W'(req_i.a[EST_W-1:0]) * PROD_W'(req_i.b);
    q     = acc_q;
    part  = '0;
    case (req_i.op)
      ALU_MUL: begin
        acc_d = LAT_W'(prod);
      end
      ALU_DIV_LOAD: begin
        // divide magnitudes, fix the sign afterwards (truncates toward zero)
        neg_d = req_i.a[LAT_W-1];
        acc_d = req_i.a[LAT_W-1] ? (~req_i.a + LAT_W'(1)) : req_i.a;
        rem_d = '0;
        div_d = (req_i.b == '0) ? WEIGHT_W'(1) : req_i.b;
      end
      ALU_DIV_STEP: begin
        rem_d = rem_q;
        for (int k = 0; k < DIV_BITS; k++) begin
          part = {rem_d, q[LAT_W-1]};
          q    = {q[LAT_W-2:0], 1'b0};
          if (part >= {1'b0, div_q}) begin
            part = part - {1'b0, div_q};
            q[0] = 1'b1;
          end
          rem_d = part[WEIGHT_W-1:0];
        end
        acc_d = q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign mag   = {1'b0, acc_q};
  assign res_o = acc_q;
  assign key_o = $signed(neg_q ? (~mag + KEY_W'(1)) : mag);

endmodule

### sv/backend_load_balancer_select_top.sv
// channel  | handshake                | payload
// ---------+--------------------------+-----------------------------------------------
// in       | in_valid_i / in_stall_o  | op, entry_index, weight, up, est, pend, latency
// out      | out_valid_o / out_stall_i| found, chosen_index
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index (0 policy, 1 backend_count), cfg_data
//
// one word in, one word out; a new word is taken only when the sequencer is idle.
// the least-connection and latency scans share one multiply/divide unit; the
// latency policy runs 5 divide steps per entry in it.
// up-only round robin makes one table read per advance.
// a finished word waits in the output register while out_stall_i is high.
// reset clears the sequencer, config and counters; table entries start undefined.
module backend_load_balancer_select_top import bls_pkg::*; #(
  parameter int unsigned MAX_BACKENDS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [IN_IDX_W-1:0]    entry_index_i,
  input  logic [WEIGHT_W-1:0]    entry_weight_i,
  input  logic                   entry_up_i,
  input  logic [EST_W-1:0]       entry_established_i,
  input  logic [PEND_W-1:0]      entry_pending_i,
  input  logic signed [LAT_W-1:0] entry_latency_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   found_o,
  output logic [OUT_IDX_W-1:0]   chosen_index_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_CMPM   = 4'd5;
  localparam logic [3:0] S_DIVS   = 4'd6;
  localparam logic [3:0] S_CMPD   = 4'd7;
  localparam logic [3:0] S_UPADDR = 4'd8;
  localparam logic [3:0] S_UPCHK  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  function automatic logic [CNT_W-1:0] advance(logic [CNT_W-1:0] c, logic [CNT_W-1:0] n);
    logic [CNT_W:0] nx;
    nx = {1'b0, c} + (CNT_W+1)'(1);
    return (nx >= {1'b0, n}) ? '0 : nx[CNT_W-1:0];
  endfunction

  logic [3:0]              state_q, state_d;
  logic [POL_W-1:0]        policy_q, policy_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        rr_q, rr_d;
  logic [CNT_W-1:0]        uprr_q, uprr_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic [CNT_W-1:0]        tries_q, tries_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    have_q, have_d;
  logic [CNT_W-1:0]        sel_q, sel_d;
  logic                    res_found_q, res_found_d;
  logic [CNT_W-1:0]        res_idx_q, res_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q, out_found_d;
  logic [OUT_IDX_W-1:0]    out_idx_q, out_idx_d;

  // current candidate
  logic [WEIGHT_W-1:0]     c_w_q, c_w_d;
  logic [EST_W-1:0]        c_est_q, c_est_d;
  logic [PEND_W-1:0]       c_pend_q, c_pend_d;
  logic [LAT_W-1:0]        c_lat_q, c_lat_d;
  logic signed [KEY_W-1:0] c_key_q, c_key_d;
  logic [PROD_W-1:0]       prod_q, prod_d;

  logic [CNT_W-1:0]        n_w;
  logic [CNT_W-1:0]        rr_adv;
  logic [CNT_W-1:0]        uprr_adv;
  logic                    in_acc;
  logic                    out_load;
  logic                    take;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                  rd_data;

  alu_req_t                alu_req;
  logic [LAT_W-1:0]        alu_res;
  logic signed [KEY_W-1:0] alu_key;

  assign n_w      = (32'(count_q) > MAX_BACKENDS) ? CNT_W'(MAX_BACKENDS) : count_q;
  assign rr_adv   = advance(rr_q, n_w);
  assign uprr_adv = advance(uprr_q, n_w);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign rd_data  = entry_t'(ram_rdata);

  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign chosen_index_o = out_idx_q;

  // table write straight from the accepted word
  assign ram_we                = in_acc && (op_i == OP_WRITE) &&
                                 (32'(entry_index_i) < MAX_BACKENDS);
  assign ram_waddr             = IDX_W'(entry_index_i);
  assign ram_wdata.weight      = entry_weight_i;
  assign ram_wdata.up          = entry_up_i;
  assign ram_wdata.established = entry_established_i;
  assign ram_wdata.pending     = entry_pending_i;
  assign ram_wdata.latency     = entry_latency_i;
  assign ram_raddr = (state_q == S_UPADDR) ? IDX_W'(uprr_adv) : IDX_W'(scan_q);

  bls_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BACKENDS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bls_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res),
    .key_o (alu_key)
  );

  always_comb begin
    policy_d = policy_q;
    count_d  = count_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLICY: policy_d = cfg_data_i[POL_W-1:0];
        REG_COUNT:  count_d  = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    rr_d        = rr_q;
    uprr_d      = uprr_q;
    scan_d      = scan_q;
    tries_d     = tries_q;
    step_d      = step_q;
    have_d      = have_q;
    sel_d       = sel_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    c_w_d       = c_w_q;
    c_est_d     = c_est_q;
    c_pend_d    = c_pend_q;
    c_lat_d     = c_lat_q;
    c_key_d     = c_key_q;
    prod_d      = prod_q;
    ram_re      = 1'b0;
    take        = 1'b0;
    out_load    = 1'b0;
    alu_req.op  = ALU_NOP;
    alu_req.a   = '0;
    alu_req.b   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_SELECT) begin
            state_d = S_START;
          end else begin
            res_found_d = 1'b0;
            res_idx_d   = '0;
            state_d     = S_DONE;
          end
        end
      end
      S_START: begin
        if (n_w == '0) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = S_DONE;
        end else begin
          case (policy_q)
            POL_RR: begin
              rr_d        = rr_adv;
              res_found_d = 1'b1;
              res_idx_d   = rr_adv;
              state_d     = S_DONE;
            end
            POL_LEAST_CONN, POL_LATENCY, POL_PENDING: begin
              scan_d  = '0;
              have_d  = 1'b0;
              sel_d   = '0;
              state_d = S_ADDR;
            end
            default: begin
              tries_d = '0;
              state_d = S_UPADDR;
            end
          endcase
        end
      end
      S_ADDR: begin
        if (scan_q == n_w) begin
          res_found_d = (policy_q == POL_LEAST_CONN) ? have_q : 1'b1;
          res_idx_d   = have_q ? sel_q : '0;
          state_d     = S_DONE;
        end else if (have_q && (((policy_q == POL_LATENCY) && c_lat_q[LAT_W-1]) ||
                                ((policy_q == POL_PENDING) && (c_pend_q == '0)))) begin
          // unknown latency or an idle backend wins at once
          res_found_d = 1'b1;
          res_idx_d   = sel_q;
          state_d     = S_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (policy_q)
          POL_LEAST_CONN: begin
            if ((rd_data.weight == '0) || !rd_data.up) begin
              scan_d  = scan_q + CNT_W'(1);
              state_d = S_ADDR;
            end else if (!have_q) begin
              take    = 1'b1;
              scan_d  = scan_q + CNT_W'(1);
              state_d = S_ADDR;
            end else if (c_est_q == '0) begin
              res_found_d = 1'b1;
              res_idx_d   = sel_q;
              state_d     = S_DONE;
            end else begin
              alu_req.op = ALU_MUL;
              alu_req.a  = LAT_W'(c_est_q);
              alu_req.b  = rd_data.weight;
              state_d    = S_MUL2;
            end
          end
          POL_LATENCY: begin
            alu_req.op = ALU_DIV_LOAD;
            alu_req.a  = rd_data.latency;
            alu_req.b  = rd_data.weight;
            step_d     = '0;
            state_d    = S_DIVS;
          end
          default: begin
            if (!have_q || (rd_data.pending < c_pend_q)) begin
              take = 1'b1;
            end
            scan_d  = scan_q + CNT_W'(1);
            state_d = S_ADDR;
          end
        endcase
      end
      S_MUL2: begin
        // first product is in the unit, start the second
        prod_d     = alu_res[PROD_W-1:0];
        alu_req.op = ALU_MUL;
        alu_req.a  = LAT_W'(rd_data.established);
        alu_req.b  = c_w_q;
        state_d    = S_CMPM;
      end
      S_CMPM: begin
        if (prod_q > alu_res[PROD_W-1:0]) begin
          take = 1'b1;
        end
        scan_d  = scan_q + CNT_W'(1);
        state_d = S_ADDR;
      end
      S_DIVS: begin
        alu_req.op = ALU_DIV_STEP;
        step_d     = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_CMPD;
        end
      end
      S_CMPD: begin
        if (!have_q || (alu_key < c_key_q)) begin
          take = 1'b1;
        end
        scan_d  = scan_q + CNT_W'(1);
        state_d = S_ADDR;
      end
      S_UPADDR: begin
        if (tries_q == n_w) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = S_DONE;
        end else begin
          uprr_d  = uprr_adv;
          tries_d = tries_q + CNT_W'(1);
          ram_re  = 1'b1;
          state_d = S_UPCHK;
        end
      end
      S_UPCHK: begin
        if (rd_data.up) begin
          res_found_d = 1'b1;
          res_idx_d   = uprr_q;
          state_d     = S_DONE;
        end else begin
          state_d = S_UPADDR;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (take) begin
      have_d   = 1'b1;
      sel_d    = scan_q;
      c_w_d    = rd_data.weight;
      c_est_d  = rd_data.established;
      c_pend_d = rd_data.pending;
      c_lat_d  = rd_data.latency;
      c_key_d  = alu_key;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_idx_d   = res_idx_q[OUT_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POL_RR;
      count_q     <= '0;
      rr_q        <= '0;
      uprr_q      <= '0;
      scan_q      <= '0;
      tries_q     <= '0;
      step_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      count_q     <= count_d;
      rr_q        <= rr_d;
      uprr_q      <= uprr_d;
      scan_q      <= scan_d;
      tries_q     <= tries_d;
      step_q      <= step_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    c_w_q       <= c_w_d;
    c_est_q     <= c_est_d;
    c_pend_q    <= c_pend_d;
    c_lat_q     <= c_lat_d;
    c_key_q     <= c_key_d;
    prod_q      <= prod_d;
  end

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> chosen_index_o == '0)
    else $error("not-found word carries a nonzero index");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && res_found_q |-> res_idx_q < n_w)
    else $error("selected index beyond backend count");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted word dropped by sequencer");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |-> scan_q <= n_w)
    else $error("scan ran past the backend count");

  a_tries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPADDR) |-> tries_q <= n_w)
    else $error("up-only search ran past the backend count");

endmodule
